FILE: design/msbm_pkg.sv
// ----------------------------------------------------------------------------
// msbm_pkg
// Shared types, field widths and command codes of the signature byte matcher.
// ----------------------------------------------------------------------------
package msbm_pkg;

  localparam int NUM_SIGS_DEF    = 8;
  localparam int MAX_SIG_LEN_DEF = 32;

  // request field widths
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 3;
  localparam int POS_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int SLEN_W  = 6;
  localparam int OFS_W   = 32;

  localparam int S_TDATA_W = 24;   // slot, pos, byte, length, zero fill
  localparam int M_TDATA_W = 40;   // slot, offset, zero fill

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_LENGTH = 2'd2,
    CMD_SCAN   = 2'd3
  } msbm_cmd_t;

  // broadcast to every signature cell
  typedef struct packed {
    logic              step;   // advance the partial-match bits
    logic              clr;    // drop all partial matches
    logic [BYTE_W-1:0] data;   // file byte being matched
  } msbm_feed_t;

endpackage

FILE: design/msbm_hist_cell.sv
// ----------------------------------------------------------------------------
// msbm_hist_cell
// One stage of the file history line: a byte and a valid flag.
// ----------------------------------------------------------------------------
module msbm_hist_cell
  import msbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              clr,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              valid_in,
  output logic [BYTE_W-1:0] byte_q,
  output logic              valid_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (clr) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

endmodule

FILE: design/msbm_sig_cell.sv
// ----------------------------------------------------------------------------
// msbm_sig_cell
// One signature position: holds the signature byte and the partial-match bit
// (prefix up to here equals the latest file bytes), passed on to the next cell.
// ----------------------------------------------------------------------------
module msbm_sig_cell
  import msbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  msbm_feed_t        feed,
  input  logic              wr_en,
  input  logic [BYTE_W-1:0] wr_byte,
  input  logic              prev_match,
  input  logic              tail,
  output logic              match_q,
  output logic              hit
);

  logic [BYTE_W-1:0] sig_byte;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sig_byte <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else if (feed.clr) begin
      match_q <= 1'b0;
    end else if (feed.step) begin
      match_q <= prev_match && (sig_byte == feed.data);
    end
  end

  // full signature ends here when this is the slot's last position
  assign hit = match_q && tail;

endmodule

FILE: design/msbm_emit.sv
// ----------------------------------------------------------------------------
// msbm_emit
// Holds the match set of one byte and sends one result per matching slot, lowest first.
// ----------------------------------------------------------------------------
module msbm_emit
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS = NUM_SIGS_DEF,
  parameter int LEN_W    = 6
)(
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [NUM_SIGS-1:0]                ld_mask,
  input  logic [OFS_W-1:0]                   ld_here,
  input  logic [NUM_SIGS-1:0][LEN_W-1:0]     ld_len,
  output logic                               busy,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [M_TDATA_W-1:0]               m_tdata,
  output logic                               m_tlast
);

  logic [NUM_SIGS-1:0]            e_mask;
  logic [OFS_W-1:0]               e_here;
  logic [NUM_SIGS-1:0][LEN_W-1:0] e_len;

  logic [SLOT_W-1:0]   m_slot;
  logic [OFS_W-1:0]    m_offset;

  logic [SLOT_W-1:0]   sel_slot;
  logic [LEN_W-1:0]    sel_len;
  logic [NUM_SIGS-1:0] rest_mask;
  logic                pop;

  // lowest set slot wins
  always_comb begin
    sel_slot  = '0;
    sel_len   = '0;
    rest_mask = e_mask;
    for (int s = NUM_SIGS - 1; s >= 0; s--) begin
      if (e_mask[s]) begin
        sel_slot  = SLOT_W'(s);
        sel_len   = e_len[s];
        rest_mask = e_mask;
        rest_mask[s] = 1'b0;
      end
    end
  end

  assign busy = (e_mask != '0);
  assign pop  = busy && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_mask   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        e_mask <= ld_mask;
      end else if (pop) begin
        e_mask <= rest_mask;
      end
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e_here <= ld_here;
      e_len  <= ld_len;
    end
    if (pop) begin
      m_slot   <= sel_slot;
      m_offset <= e_here - OFS_W'(sel_len) + OFS_W'(1);
      m_tlast  <= (rest_mask == '0);
    end
  end

  assign m_tdata = {{(M_TDATA_W - OFS_W - SLOT_W){1'b0}}, m_offset, m_slot};

endmodule

FILE: design/multi_signature_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// multi_signature_byte_matcher_core
// Streams file bytes against a table of byte signatures and reports every
// signature that ends at the latest byte, with slot and start offset.
// A scan's match bits are registered in the cells, then in the emitter and at
// its output. Throughput: one request per cycle outside a replay; results of one
//   byte leave one per cycle unless the output stalls, and a matching byte waits
//   while the previous byte's results still drain. A signature byte write after
//   a scanned byte in the current file replays the history through the cells.
// Reset: all slots inactive, history empty, offset zero, signature bytes
//   undefined until written.
// ----------------------------------------------------------------------------
module multi_signature_byte_matcher_core
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS    = NUM_SIGS_DEF,
  parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // sig_slot, byte_pos, byte_value, sig_length
  input  logic [CMD_W-1:0]     s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // match_slot, match_offset
  output logic                 m_tlast    // last_match
);

  localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);
  localparam int CNT_W = $clog2(MAX_SIG_LEN + 1);

  // request fields
  msbm_cmd_t         cmd;
  logic [SLOT_W-1:0] sig_slot;
  logic [POS_W-1:0]  byte_pos;
  logic [BYTE_W-1:0] byte_value;
  logic [SLEN_W-1:0] sig_length;

  assign cmd        = msbm_cmd_t'(s_tuser);
  assign sig_slot   = s_tdata[SLOT_W-1:0];
  assign byte_pos   = s_tdata[SLOT_W+POS_W-1:SLOT_W];
  assign byte_value = s_tdata[SLOT_W+POS_W+BYTE_W-1:SLOT_W+POS_W];
  assign sig_length = s_tdata[SLOT_W+POS_W+BYTE_W+SLEN_W-1:SLOT_W+POS_W+BYTE_W];

  // state
  logic [NUM_SIGS-1:0][LEN_W-1:0] slen;
  logic [OFS_W-1:0]               bytes_seen;
  logic [CNT_W-1:0]               rp_cnt;
  logic                           p_valid;
  logic [OFS_W-1:0]               p_here;

  // history line, newest byte in cell 0
  logic [MAX_SIG_LEN-1:0][BYTE_W-1:0] hb;
  logic [MAX_SIG_LEN-1:0]             hv;

  logic [NUM_SIGS-1:0][MAX_SIG_LEN-1:0] pmatch;
  logic [NUM_SIGS-1:0][MAX_SIG_LEN-1:0] hit;
  logic [NUM_SIGS-1:0]                  mv;

  logic acc, scan_acc, start_acc, write_acc, len_acc;
  logic replaying, p_go, e_busy, hist_shift;
  logic [BYTE_W-1:0] head_byte;
  logic              head_valid;
  logic [LEN_W-1:0]  len_clamped;
  msbm_feed_t        feed;

  assign replaying = (rp_cnt != '0);

  // The compare of a pending scan reads the cell state directly, so hold
  // every request until that byte's match set has moved on.
  assign p_go     = p_valid && ((mv == '0) || !e_busy);
  assign s_tready = !replaying && (!p_valid || p_go);
  assign acc      = s_tvalid && s_tready;

  assign scan_acc  = acc && (cmd == CMD_SCAN);
  assign start_acc = acc && (cmd == CMD_START);
  assign write_acc = acc && (cmd == CMD_WRITE) &&
                     (32'(sig_slot) < NUM_SIGS) && (32'(byte_pos) < MAX_SIG_LEN);
  assign len_acc   = acc && (cmd == CMD_LENGTH) && (32'(sig_slot) < NUM_SIGS);

  assign len_clamped = (32'(sig_length) > MAX_SIG_LEN) ? LEN_W'(MAX_SIG_LEN)
                                                        : LEN_W'(sig_length);

  // During replay rotate the history: the oldest byte re-enters at the head
  // and drives the cells, so after MAX_SIG_LEN steps everything is back.
  assign head_byte  = replaying ? hb[MAX_SIG_LEN-1] : byte_value;
  assign head_valid = replaying ? hv[MAX_SIG_LEN-1] : 1'b1;
  assign hist_shift = scan_acc || replaying;

  always_comb begin
    feed.data = head_byte;
    feed.step = scan_acc || (replaying && hv[MAX_SIG_LEN-1]);
    // drop partial matches on a new file, before a replay, and for
    // history bytes that predate the file
    feed.clr  = start_acc || (write_acc && hv[0]) ||
                (replaying && !hv[MAX_SIG_LEN-1]);
  end

  genvar gk, gs;
  generate
    for (gk = 0; gk < MAX_SIG_LEN; gk++) begin : g_hist
      if (gk == 0) begin : g_head
        msbm_hist_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift    (hist_shift),
          .clr      (start_acc),
          .byte_in  (head_byte),
          .valid_in (head_valid),
          .byte_q   (hb[gk]),
          .valid_q  (hv[gk])
        );
      end else begin : g_body
        msbm_hist_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift    (hist_shift),
          .clr      (start_acc),
          .byte_in  (hb[gk-1]),
          .valid_in (hv[gk-1]),
          .byte_q   (hb[gk]),
          .valid_q  (hv[gk])
        );
      end
    end

    for (gs = 0; gs < NUM_SIGS; gs++) begin : g_slot
      for (gk = 0; gk < MAX_SIG_LEN; gk++) begin : g_pos
        logic wr_en;
        logic tail;
        logic prev;
        assign wr_en = write_acc && (32'(sig_slot) == gs) && (32'(byte_pos) == gk);
        assign tail  = (slen[gs] == LEN_W'(gk + 1));
        if (gk == 0) begin : g_first
          assign prev = 1'b1;
        end else begin : g_next
          assign prev = pmatch[gs][gk-1];
        end
        msbm_sig_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .feed       (feed),
          .wr_en      (wr_en),
          .wr_byte    (byte_value),
          .prev_match (prev),
          .tail       (tail),
          .match_q    (pmatch[gs][gk]),
          .hit        (hit[gs][gk])
        );
      end
      assign mv[gs] = |hit[gs];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      slen       <= '0;
      bytes_seen <= '0;
      rp_cnt     <= '0;
      p_valid    <= 1'b0;
    end else begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        if (len_acc && (32'(sig_slot) == s)) begin
          slen[s] <= len_clamped;
        end
      end
      // hold the byte count at its maximum
      if (start_acc) begin
        bytes_seen <= '0;
      end else if (scan_acc && (bytes_seen != '1)) begin
        bytes_seen <= bytes_seen + OFS_W'(1);
      end
      if (write_acc && hv[0]) begin
        rp_cnt <= CNT_W'(MAX_SIG_LEN);
      end else if (replaying) begin
        rp_cnt <= rp_cnt - CNT_W'(1);
      end
      if (scan_acc) begin
        p_valid <= 1'b1;
      end else if (p_go) begin
        p_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_acc) begin
      p_here <= bytes_seen;
    end
  end

  msbm_emit #(
    .NUM_SIGS (NUM_SIGS),
    .LEN_W    (LEN_W)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (p_go && (mv != '0)),
    .ld_mask  (mv),
    .ld_here  (p_here),
    .ld_len   (slen),
    .busy     (e_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef ASSERT_OFF
  a_no_req_in_replay: assert property (@(posedge clk) disable iff (rst)
    replaying |-> !s_tready)
    else $error("request taken while the history replays");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> (mv == '0) && (hv == '0))
    else $error("match state survives a new file");

  a_scan_pending: assert property (@(posedge clk) disable iff (rst)
    scan_acc |=> p_valid && (p_here == $past(bytes_seen)))
    else $error("scanned byte lost before compare");

  a_match_needs_room: assert property (@(posedge clk) disable iff (rst)
    (p_valid && (mv != '0) && e_busy) |=> p_valid && $stable(p_here))
    else $error("match set dropped while results drain");
`endif

endmodule
